@@ rtl/core/box_muller_gaussian_sample_defines.svh @@
// Assertion macros for the gaussian sample generator RTL.
`ifndef BOX_MULLER_GAUSSIAN_SAMPLE_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_SAMPLE_DEFINES_SVH
`ifndef SYNTHESIS
`define BMG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box_muller_gaussian_sample: same-cycle check failed");
`define BMG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box_muller_gaussian_sample: next-cycle check failed");
`else
`define BMG_ASSERT_IMP(name, ante, cons)
`define BMG_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ rtl/core/bmg_pkg.sv @@
// Constants, types and product helpers of the gaussian sample generator.
package bmg_pkg;

  localparam int unsigned WordWidth     = 32;
  localparam int unsigned InDataWidth   = 2 * WordWidth;
  localparam int unsigned CfgIndexWidth = 8;

  localparam logic [CfgIndexWidth-1:0] CfgMeanOffset   = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CfgStdDeviation = 8'd1;

  localparam int unsigned FracBits = 16;
  localparam logic [31:0] StdReset = 32'd1 << FracBits;

  localparam logic [63:0] Ln2Q64    = 64'hB17217F7D1CF79AC;
  localparam logic [63:0] HalfPiQ62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] OneQ61    = 64'h2000000000000000;

  localparam int unsigned LogSteps  = 32;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned NumTerms  = 12;

  // Input regs, exponent, log chain, t, ln2 products, sqrt chain.
  localparam int unsigned RadiusDepth = 2 + (LogSteps + 1) + 2 + (SqrtSteps + 1);
  // Fold, two angle stages, two a^2 stages, series, clamp, z and scale stages.
  localparam int unsigned SineDepth   = 5 + 4 * NumTerms + 5;
  localparam int unsigned PipeDepth   = RadiusDepth + SineDepth;

  // Four 32x32 partial products of a 64x64 multiply.
  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
  } pp4_t;

  function automatic pp4_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp4_t p;
    p.ll = a[31:0] * b[31:0];
    p.lh = a[31:0] * b[63:32];
    p.hl = a[63:32] * b[31:0];
    p.hh = a[63:32] * b[63:32];
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(input pp4_t p);
    return {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
  endfunction

endpackage

@@ rtl/core/box_muller_gaussian_sample.sv @@
// Top level of the Box-Muller gaussian sample generator (sine branch).
`include "box_muller_gaussian_sample_defines.svh"

// Each request carries two raw 32-bit uniform words and yields one signed Q16.16
// gaussian sample, mean_offset + std_deviation * sqrt(-2 ln u1) * sin(2 pi u2),
// rounded and saturated to the 32-bit signed range. The datapath is a fully
// pipelined chain of 128 register stages plus the output register, so one
// request is taken every clock while the output is not stalled. The depth is
// set by the 32 squaring stages of the log2, the 32 digit stages of the square
// root and the four stages per sine series term.
// A stall on the output freezes the whole chain; s_axis_tready_o follows the
// output register, so a new request is taken whenever the waiting result is
// being taken in the same cycle or none waits. Configuration writes are always
// taken and should only happen while no request is in flight.
module box_muller_gaussian_sample (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [31:0] radius_word, [63:32] angle_word
  input  logic [bmg_pkg::InDataWidth-1:0]       s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [31:0] normal_sample
  output logic [bmg_pkg::WordWidth-1:0]         m_axis_tdata_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bmg_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [bmg_pkg::WordWidth-1:0]         cfg_data_i
);
  import bmg_pkg::*;

  // Global advance: every stage moves when the output register can move.
  logic                 adv;
  logic                 out_vld_q;
  logic [PipeDepth-1:0] vld_q;
  logic [31:0]          out_data_q;
  logic [31:0]          mean_q;
  logic [31:0]          std_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[PipeDepth-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[PipeDepth-1];
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= StdReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMeanOffset:   mean_q <= cfg_data_i;
        CfgStdDeviation: std_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Radius path: -log2(u1), then 2 ln2 scaling, then the square root.
  // ---------------------------------------------------------------------------
  logic [31:0] w0_q, w1_q;
  logic [5:0]  e_d, e1_q;
  logic [31:0] ang_q [RadiusDepth];
  logic [32:0] x_d;
  logic [63:0] xs_d;
  logic [31:0] m0_d;

  // The exponent is the position of the top set bit of 2w+1.
  always_comb begin
    e_d = '0;
    for (int j = 0; j < 32; j++) begin
      if (w0_q[j]) e_d = 6'(j + 1);
    end
  end

  assign x_d  = {w1_q, 1'b1};
  assign xs_d = {31'd0, x_d} << (6'd31 - e1_q);
  assign m0_d = (e1_q == 6'd32) ? w1_q : xs_d[31:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w0_q     <= s_axis_tdata_i[31:0];
      ang_q[0] <= s_axis_tdata_i[63:32];
      w1_q     <= w0_q;
      e1_q     <= e_d;
      for (int i = 1; i < RadiusDepth; i++) ang_q[i] <= ang_q[i-1];
    end
  end

  // Fraction bits of log2 by repeated squaring of the Q1.31 mantissa.
  logic [31:0] lm_q [LogSteps+1];
  logic [31:0] lf_q [LogSteps+1];
  logic [5:0]  le_q [LogSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lm_q[0] <= m0_d;
      lf_q[0] <= '0;
      le_q[0] <= e1_q;
    end
  end

  for (genvar gl = 0; gl < LogSteps; gl++) begin : g_log
    logic [63:0] sq;
    assign sq = lm_q[gl] * lm_q[gl];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        lm_q[gl+1] <= sq[63] ? sq[63:32] : sq[62:31];
        lf_q[gl+1] <= {lf_q[gl][30:0], sq[63]};
        le_q[gl+1] <= le_q[gl];
      end
    end
  end

  logic [37:0]  t_q;
  pp4_t         pv_q;
  logic [127:0] vsum_d;
  logic [63:0]  sv_q [SqrtSteps+1];
  logic [63:0]  sr_q [SqrtSteps+1];

  assign vsum_d = pp_sum(pv_q) + (128'd1 << 36);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q     <= {6'd33 - le_q[LogSteps], 32'd0} - {6'd0, lf_q[LogSteps]};
      pv_q    <= mul_pp({26'd0, t_q}, Ln2Q64);
      sv_q[0] <= vsum_d[100:37];
      sr_q[0] <= '0;
    end
  end

  // One result bit of the integer square root per stage.
  for (genvar gs = 0; gs < SqrtSteps; gs++) begin : g_sqrt
    localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * gs);
    logic [63:0] trial;
    logic        fits;
    assign trial = sr_q[gs] + SqBit;
    assign fits  = sv_q[gs] >= trial;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sv_q[gs+1] <= fits ? sv_q[gs] - trial : sv_q[gs];
        sr_q[gs+1] <= fits ? (sr_q[gs] >> 1) + SqBit : sr_q[gs] >> 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Angle path: quadrant fold, angle scaling, Taylor series of the sine.
  // ---------------------------------------------------------------------------
  logic [33:0]  qr_q [SineDepth];   // {quadrant, radius}
  logic [30:0]  f31_d;
  logic [31:0]  fq_q;
  pp4_t         pa_q, pb_q;
  logic [127:0] asum_d, bsum_d;
  logic [63:0]  a_q, ab_q;
  logic [63:0]  tm_q  [NumTerms+1];
  logic [63:0]  sm_q  [NumTerms+1];
  logic [63:0]  a2m_q [NumTerms+1];

  assign f31_d  = {ang_q[RadiusDepth-1][29:0], 1'b1};
  assign asum_d = pp_sum(pa_q) + (128'd1 << 31);
  assign bsum_d = pp_sum(pb_q) + (128'd1 << 60);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qr_q[0] <= {ang_q[RadiusDepth-1][31:30], sr_q[SqrtSteps][31:0]};
      for (int i = 1; i < SineDepth; i++) qr_q[i] <= qr_q[i-1];
      // Odd quadrants mirror the phase inside the quarter turn.
      fq_q     <= ang_q[RadiusDepth-1][30] ? 32'h8000_0000 - {1'b0, f31_d}
                                           : {1'b0, f31_d};
      pa_q     <= mul_pp({32'd0, fq_q}, HalfPiQ62);
      a_q      <= asum_d[95:32];
      pb_q     <= mul_pp(a_q, a_q);
      ab_q     <= a_q;
      tm_q[0]  <= ab_q;
      sm_q[0]  <= ab_q;
      a2m_q[0] <= bsum_d[124:61];
    end
  end

  // Each term: multiply by a^2, round, divide by (2k)(2k+1) through a
  // reciprocal product with a one-step correction. The previous term is
  // folded into the running sum in the first stage of the next term.
  for (genvar gk = 1; gk <= NumTerms; gk++) begin : g_term
    localparam logic [9:0]  Div      = 10'((2 * gk) * (2 * gk + 1));
    localparam logic [63:0] Recip    = 64'hFFFF_FFFF_FFFF_FFFF / Div;
    localparam bit          First    = (gk == 1);
    localparam bit          SubPrev  = (((gk - 1) % 2) == 1);
    pp4_t         pt_q, pr_q;
    logic [63:0]  s_upd, s1_q, s2_q, s3_q, a21_q, a22_q, a23_q, x2_q, x3_q;
    logic [127:0] xsum, rsum;
    logic [63:0]  q0, rem;

    assign s_upd = First ? sm_q[gk-1]
                 : (SubPrev ? sm_q[gk-1] - tm_q[gk-1] : sm_q[gk-1] + tm_q[gk-1]);
    assign xsum  = pp_sum(pt_q) + (128'd1 << 60);
    assign rsum  = pp_sum(pr_q);
    assign q0    = rsum[127:64];
    assign rem   = x3_q - q0 * Div;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pt_q      <= mul_pp(tm_q[gk-1], a2m_q[gk-1]);
        s1_q      <= s_upd;
        a21_q     <= a2m_q[gk-1];
        x2_q      <= xsum[124:61];
        s2_q      <= s1_q;
        a22_q     <= a21_q;
        pr_q      <= mul_pp(x2_q, Recip);
        x3_q      <= x2_q;
        s3_q      <= s2_q;
        a23_q     <= a22_q;
        tm_q[gk]  <= (rem >= 64'(Div)) ? q0 + 64'd1 : q0;
        sm_q[gk]  <= s3_q;
        a2m_q[gk] <= a23_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: clamp the sine, z = r * s, scale, sign, mean, saturate.
  // ---------------------------------------------------------------------------
  localparam bit LastSub = ((NumTerms % 2) == 1);

  logic [63:0]         ssum_d, s_fin_q;
  pp4_t                pz_q, pm_q;
  logic [127:0]        zsum_d, msum_d;
  logic [33:0]         z_q;
  logic [36:0]         mag_q;
  logic signed [38:0]  mag_s_d, total_d;

  assign ssum_d  = LastSub ? sm_q[NumTerms] - tm_q[NumTerms]
                           : sm_q[NumTerms] + tm_q[NumTerms];
  assign zsum_d  = pp_sum(pz_q) + (128'd1 << 59);
  assign msum_d  = pp_sum(pm_q) + (128'd1 << 29);
  // Rounding happened on the magnitude, so ties go away from zero.
  assign mag_s_d = qr_q[SineDepth-1][33] ? -$signed({2'b00, mag_q})
                                         :  $signed({2'b00, mag_q});
  assign total_d = mag_s_d + 39'($signed(mean_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_fin_q <= (ssum_d > OneQ61) ? OneQ61 : ssum_d;
      pz_q    <= mul_pp({32'd0, qr_q[SineDepth-5][31:0]}, s_fin_q);
      z_q     <= zsum_d[93:60];
      pm_q    <= mul_pp({32'd0, std_q}, {30'd0, z_q});
      mag_q   <= msum_d[66:30];
      if (total_d > 39'sd2147483647) begin
        out_data_q <= 32'h7FFF_FFFF;
      end else if (total_d < -39'sd2147483648) begin
        out_data_q <= 32'h8000_0000;
      end else begin
        out_data_q <= total_d[31:0];
      end
    end
  end

  // A held output must freeze every valid bit of the chain.
  `BMG_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_q) && $stable(out_vld_q))
  // The log mantissa is still normalized to [1, 2) after the last squaring.
  `BMG_ASSERT_IMP(a_log_norm, vld_q[2 + LogSteps], lm_q[LogSteps][31])
  // The square root of a 64-bit value fits in 32 bits.
  `BMG_ASSERT_IMP(a_sqrt_range, vld_q[RadiusDepth-1], sr_q[SqrtSteps][63:32] == 32'd0)

endmodule
